[design/ptss_pkg.sv]
// Shared types and constants for the periodic task slot scheduler.
// Used by ptss_slot_table and periodic_task_slot_scheduler; no dependencies.
`default_nettype none

package ptss_pkg;

  localparam int unsigned NUM_SLOTS = 16;
  localparam int unsigned IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [3:0] slot_t;

  typedef enum logic [2:0] {
    KIND_TICK    = 3'd0,
    KIND_CREATE  = 3'd1,
    KIND_EDIT    = 3'd2,
    KIND_PAUSE   = 3'd3,
    KIND_RESUME  = 3'd4,
    KIND_DESTROY = 3'd5
  } kind_e;

  localparam logic [1:0] MODE_WAITING = 2'd0;
  localparam logic [1:0] MODE_PAUSED  = 2'd1;

  localparam logic RK_STATUS = 1'b0;
  localparam logic RK_FIRE   = 1'b1;

  localparam logic ST_OK  = 1'b0;
  localparam logic ST_ERR = 1'b1;

  typedef enum logic [2:0] {
    TBL_NONE,
    TBL_CREATE,
    TBL_EDIT,
    TBL_SET_MODE,
    TBL_FREE,
    TBL_FIRE
  } tbl_op_e;

  // Update request from the sequencer to the slot table.
  typedef struct packed {
    tbl_op_e     op;
    idx_t        idx;
    logic [31:0] interval;
    logic [31:0] runs;
    logic [1:0]  mode;
    logic [31:0] now;
  } tbl_cmd_t;

  // Status returned by the slot table.
  typedef struct packed {
    logic [NUM_SLOTS-1:0] used;
    logic                 fire;
    logic                 full;
    idx_t                 free_idx;
  } tbl_stat_t;

endpackage

`default_nettype wire

[design/ptss_slot_table.sv]
// Task slot storage with the per-slot due check and the lowest-free-slot finder.
// Depends on ptss_pkg.
`default_nettype none

module ptss_slot_table (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire ptss_pkg::tbl_cmd_t cmd_i,
  input  wire ptss_pkg::idx_t     rd_idx_i,
  input  wire logic [31:0]        scan_now_i,
  output ptss_pkg::tbl_stat_t     stat_o
);

  logic [ptss_pkg::NUM_SLOTS-1:0] used_q;
  logic [31:0] interval_q [ptss_pkg::NUM_SLOTS];
  logic [31:0] runs_q     [ptss_pkg::NUM_SLOTS];
  logic [1:0]  mode_q     [ptss_pkg::NUM_SLOTS];
  logic [31:0] last_q     [ptss_pkg::NUM_SLOTS];
  logic        finite_q   [ptss_pkg::NUM_SLOTS];

  logic [31:0] rd_runs;
  logic [31:0] elapsed;
  logic        full;
  ptss_pkg::idx_t free_idx;

  assign rd_runs = runs_q[rd_idx_i];
  // Elapsed time wraps modulo 2^32 just like the time base.
  assign elapsed = scan_now_i - last_q[rd_idx_i];

  always_comb begin
    full     = 1'b1;
    free_idx = '0;
    for (int i = ptss_pkg::NUM_SLOTS - 1; i >= 0; i--) begin
      if (!used_q[i]) begin
        full     = 1'b0;
        free_idx = ptss_pkg::idx_t'(i);
      end
    end
  end

  assign stat_o.used     = used_q;
  assign stat_o.fire     = used_q[rd_idx_i] && (mode_q[rd_idx_i] == ptss_pkg::MODE_WAITING) &&
                           (elapsed >= interval_q[rd_idx_i]);
  assign stat_o.full     = full;
  assign stat_o.free_idx = free_idx;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q <= '0;
    end else begin
      unique case (cmd_i.op)
        ptss_pkg::TBL_CREATE: used_q[cmd_i.idx] <= 1'b1;
        ptss_pkg::TBL_FREE:   used_q[cmd_i.idx] <= 1'b0;
        ptss_pkg::TBL_FIRE: begin
          // A finite slot that fires on its final run is released.
          if (finite_q[rd_idx_i] && (rd_runs == 32'd1)) used_q[rd_idx_i] <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (cmd_i.op)
      ptss_pkg::TBL_CREATE: begin
        interval_q[cmd_i.idx] <= cmd_i.interval;
        runs_q[cmd_i.idx]     <= cmd_i.runs;
        mode_q[cmd_i.idx]     <= cmd_i.mode;
        last_q[cmd_i.idx]     <= cmd_i.now;
        finite_q[cmd_i.idx]   <= (cmd_i.runs != 32'd0);
      end
      ptss_pkg::TBL_EDIT: begin
        interval_q[cmd_i.idx] <= cmd_i.interval;
        runs_q[cmd_i.idx]     <= cmd_i.runs;
        mode_q[cmd_i.idx]     <= cmd_i.mode;
      end
      ptss_pkg::TBL_SET_MODE: begin
        mode_q[cmd_i.idx] <= cmd_i.mode;
      end
      ptss_pkg::TBL_FIRE: begin
        last_q[rd_idx_i] <= scan_now_i;
        mode_q[rd_idx_i] <= ptss_pkg::MODE_WAITING;
        if (finite_q[rd_idx_i]) runs_q[rd_idx_i] <= rd_runs - 32'd1;
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

[design/periodic_task_slot_scheduler.sv]
// Top level of the periodic task slot scheduler: command decode and tick sequencer.
// Depends on ptss_pkg and ptss_slot_table.
`default_nettype none

// A beat is taken when start_i is high and busy_o is low. Create, edit, pause,
// resume and destroy are handled in the accepting cycle; busy_o stays low and
// their single status beat appears on the next cycle. A tick holds busy_o high
// through the scan and flush states: the shared slot evaluation unit checks one
// slot per cycle in index order, and the flush state then issues the final fired
// beat, if any. Each fired beat is held until the next slot fires or the scan
// ends, so that the last flag is known when it is shown. Every result is on
// the ports for one cycle, marked by done_o; the receiver cannot stall, so it
// must take every beat.
module periodic_task_slot_scheduler (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  output logic             busy_o,
  input  wire logic [2:0]  kind_i,
  input  wire logic [3:0]  slot_i,
  input  wire logic [31:0] interval_ms_i,
  input  wire logic [31:0] run_count_i,
  input  wire logic [1:0]  task_state_i,
  input  wire logic [31:0] now_ms_i,
  output logic             done_o,
  output logic             result_kind_o,
  output logic [3:0]       result_slot_o,
  output logic             status_o,
  output logic             last_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FLUSH
  } state_e;

  state_e         state_q;
  ptss_pkg::idx_t idx_q;
  logic [31:0]    now_q;
  logic           pend_q;
  ptss_pkg::idx_t pend_idx_q;
  logic           done_q;
  logic           rkind_q;
  logic [3:0]     rslot_q;
  logic           status_q;
  logic           last_q;

  ptss_pkg::tbl_cmd_t  tbl_cmd;
  ptss_pkg::tbl_stat_t tbl_stat;

  logic           accept;
  logic           slot_ok;
  logic           present;
  ptss_pkg::idx_t slot_idx;
  logic [3:0]     res_slot;
  logic           res_err;

  assign busy_o = (state_q != S_IDLE);
  assign accept = start_i && !busy_o;

  assign slot_ok  = (32'(slot_i) < ptss_pkg::NUM_SLOTS);
  assign slot_idx = ptss_pkg::idx_t'(slot_i);
  assign present  = slot_ok && tbl_stat.used[slot_idx];

  always_comb begin
    tbl_cmd.op       = ptss_pkg::TBL_NONE;
    tbl_cmd.idx      = slot_idx;
    tbl_cmd.interval = interval_ms_i;
    tbl_cmd.runs     = run_count_i;
    tbl_cmd.mode     = task_state_i;
    tbl_cmd.now      = now_ms_i;
    res_slot         = slot_i;
    res_err          = ptss_pkg::ST_ERR;
    unique case (kind_i)
      ptss_pkg::KIND_TICK: ;
      ptss_pkg::KIND_CREATE: begin
        res_slot = '0;
        if (!tbl_stat.full) begin
          tbl_cmd.op  = ptss_pkg::TBL_CREATE;
          tbl_cmd.idx = tbl_stat.free_idx;
          res_slot    = ptss_pkg::slot_t'(tbl_stat.free_idx);
          res_err     = ptss_pkg::ST_OK;
        end
      end
      ptss_pkg::KIND_EDIT: begin
        tbl_cmd.op = ptss_pkg::TBL_EDIT;
      end
      ptss_pkg::KIND_PAUSE: begin
        tbl_cmd.op   = ptss_pkg::TBL_SET_MODE;
        tbl_cmd.mode = ptss_pkg::MODE_PAUSED;
      end
      ptss_pkg::KIND_RESUME: begin
        tbl_cmd.op   = ptss_pkg::TBL_SET_MODE;
        tbl_cmd.mode = ptss_pkg::MODE_WAITING;
      end
      ptss_pkg::KIND_DESTROY: begin
        tbl_cmd.op = ptss_pkg::TBL_FREE;
      end
      default: ;
    endcase
    if (tbl_cmd.op != ptss_pkg::TBL_CREATE && tbl_cmd.op != ptss_pkg::TBL_NONE) begin
      if (present) begin
        res_err = ptss_pkg::ST_OK;
      end else begin
        tbl_cmd.op = ptss_pkg::TBL_NONE;
      end
    end
    if (!accept) tbl_cmd.op = ptss_pkg::TBL_NONE;
    // During a tick the only update is the slot being checked firing.
    if (state_q == S_SCAN && tbl_stat.fire) tbl_cmd.op = ptss_pkg::TBL_FIRE;
  end

  ptss_slot_table u_table (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (tbl_cmd),
    .rd_idx_i  (idx_q),
    .scan_now_i(now_q),
    .stat_o    (tbl_stat)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      idx_q      <= '0;
      now_q      <= '0;
      pend_q     <= 1'b0;
      pend_idx_q <= '0;
      done_q     <= 1'b0;
      rkind_q    <= ptss_pkg::RK_STATUS;
      rslot_q    <= '0;
      status_q   <= ptss_pkg::ST_OK;
      last_q     <= 1'b0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            if (kind_i == ptss_pkg::KIND_TICK) begin
              state_q <= S_SCAN;
              idx_q   <= '0;
              now_q   <= now_ms_i;
              pend_q  <= 1'b0;
            end else begin
              done_q   <= 1'b1;
              rkind_q  <= ptss_pkg::RK_STATUS;
              rslot_q  <= res_slot;
              status_q <= res_err;
              last_q   <= 1'b1;
            end
          end
        end
        S_SCAN: begin
          if (tbl_stat.fire) begin
            // A newer firing proves the held one is not the final beat.
            if (pend_q) begin
              done_q   <= 1'b1;
              rkind_q  <= ptss_pkg::RK_FIRE;
              rslot_q  <= ptss_pkg::slot_t'(pend_idx_q);
              status_q <= ptss_pkg::ST_OK;
              last_q   <= 1'b0;
            end
            pend_q     <= 1'b1;
            pend_idx_q <= idx_q;
          end
          if (idx_q == ptss_pkg::idx_t'(ptss_pkg::NUM_SLOTS - 1)) begin
            state_q <= S_FLUSH;
          end else begin
            idx_q <= idx_q + ptss_pkg::idx_t'(1);
          end
        end
        S_FLUSH: begin
          done_q   <= pend_q;
          rkind_q  <= ptss_pkg::RK_FIRE;
          rslot_q  <= ptss_pkg::slot_t'(pend_idx_q);
          status_q <= ptss_pkg::ST_OK;
          last_q   <= 1'b1;
          pend_q   <= 1'b0;
          state_q  <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign done_o        = done_q;
  assign result_kind_o = rkind_q;
  assign result_slot_o = rslot_q;
  assign status_o      = status_q;
  assign last_o        = last_q;

`ifndef NO_ASSERTIONS
  a_cmd_answers: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && kind_i != ptss_pkg::KIND_TICK) |=> (done_o && last_o && !result_kind_o))
    else $error("command beat did not produce a final status beat");

  a_busy_from_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(busy_o) |-> $past(start_i && kind_i == ptss_pkg::KIND_TICK))
    else $error("sequencer left idle without an accepted tick");

  a_final_fire_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && result_kind_o && last_o) |-> !busy_o)
    else $error("final fired beat shown while the tick is still running");

  a_status_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !result_kind_o) |-> !busy_o)
    else $error("status beat shown during a tick");
`endif

endmodule

`default_nettype wire
